[sv/hbp_pkg.sv]
// hbp_pkg: shared types and constants for the horizon bar placer.
// Used by hbp_front, hbp_queue, hbp_back and horizon_bar_placer_core.
// No dependencies.
package hbp_pkg;

	localparam int HBP_BAR_LEVELS   = 9;
	localparam int HBP_COL_SPAN     = 4;
	localparam int HBP_COLS         = 2 * HBP_COL_SPAN + 1;
	localparam int HBP_Y_MAX        = 81;
	localparam int HBP_PITCH_BIAS   = 4 * HBP_BAR_LEVELS + 5;
	localparam int HBP_PITCH_SCALE  = 25;
	localparam int HBP_ROLL_SHIFT   = 6;
	localparam int HBP_DIV_STEPS    = 5;
	localparam int HBP_DIV9_MUL     = 57;
	localparam int HBP_DIV9_SHIFT   = 9;
	localparam int HBP_QUEUE_DEPTH  = 4;

	localparam int HBP_CFG_IDX_W  = 3;
	localparam int HBP_CFG_DATA_W = 7;

	localparam logic [HBP_CFG_IDX_W-1:0] HBP_CFG_MAX_PITCH  = 3'd0;
	localparam logic [HBP_CFG_IDX_W-1:0] HBP_CFG_MAX_ROLL   = 3'd1;
	localparam logic [HBP_CFG_IDX_W-1:0] HBP_CFG_INVERT     = 3'd2;
	localparam logic [HBP_CFG_IDX_W-1:0] HBP_CFG_CENTER_COL = 3'd3;
	localparam logic [HBP_CFG_IDX_W-1:0] HBP_CFG_CENTER_ROW = 3'd4;

	localparam logic [6:0] HBP_RST_MAX_PITCH = 7'd20;
	localparam logic [6:0] HBP_RST_MAX_ROLL  = 7'd40;

	typedef struct packed {
		logic signed [11:0] roll_angle;
		logic signed [11:0] pitch_angle;
	} hbp_in_t;

	typedef struct packed {
		logic signed [7:0] screen_col;
		logic [5:0]        screen_row;
		logic [3:0]        bar_level;
		logic              last_bar;
	} hbp_out_t;

	typedef struct packed {
		logic [6:0] max_pitch_deg;
		logic [6:0] max_roll_deg;
		logic       invert_mode;
		logic [5:0] center_col;
		logic [4:0] center_row;
	} hbp_cfg_t;

	// clamped roll and negated, biased pitch (16..66)
	typedef struct packed {
		logic signed [11:0] roll;
		logic [6:0]         pofs;
	} hbp_cmd_t;

	typedef enum logic [1:0] {
		HBP_FS_IDLE,
		HBP_FS_DIV,
		HBP_FS_PUSH
	} hbp_front_state_t;

endpackage

[sv/hbp_front.sv]
// hbp_front: request holding register, invert and clamp, iterative pitch scaling.
// Produces one hbp_cmd_t per request for the column sequencer.
// Depends on hbp_pkg.
module hbp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hbp_pkg::hbp_in_t  in_req,
	input  hbp_pkg::hbp_cfg_t cfg,
	output logic              cmd_valid,
	input  logic              cmd_stall,
	output hbp_pkg::hbp_cmd_t cmd
);

	hbp_pkg::hbp_front_state_t state_q, state_nxt;

	logic             hold_v_q;
	hbp_pkg::hbp_in_t hold_req_q;
	logic             take;

	logic [2:0]         cnt_q;
	logic [14:0]        rem_q;
	logic [4:0]         quo_q;
	logic               neg_q;
	logic signed [11:0] roll_q;

	logic [10:0]        lim_r, lim_p;
	logic signed [12:0] roll_i, pitch_i, roll_c, pitch_c, pitch_abs;
	logic [14:0]        prod25;
	logic [15:0]        dvs, trial;
	logic               ge;

	function automatic logic signed [12:0] clamp13(input logic signed [12:0] v,
		input logic [10:0] lim);
		logic signed [12:0] l;
		l = $signed({2'b00, lim});
		if (v > l)
			return l;
		else if (v < -l)
			return -l;
		else
			return v;
	endfunction

	assign take     = hold_v_q && (state_q == hbp_pkg::HBP_FS_IDLE);
	assign in_stall = hold_v_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			hold_v_q <= 1'b1;
		end else if (take) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			hold_req_q <= in_req;
		end
	end

	// lim = deg * 10
	assign lim_r = {1'b0, cfg.max_roll_deg, 3'b000} + {3'b000, cfg.max_roll_deg, 1'b0};
	assign lim_p = {1'b0, cfg.max_pitch_deg, 3'b000} + {3'b000, cfg.max_pitch_deg, 1'b0};

	always_comb begin
		roll_i  = {hold_req_q.roll_angle[11], hold_req_q.roll_angle};
		pitch_i = {hold_req_q.pitch_angle[11], hold_req_q.pitch_angle};
		if (cfg.invert_mode) begin
			roll_i  = -roll_i;
			pitch_i = -pitch_i;
		end
		roll_c    = clamp13(roll_i, lim_r);
		pitch_c   = clamp13(pitch_i, lim_p);
		pitch_abs = pitch_c[12] ? -pitch_c : pitch_c;
		prod25    = 15'(pitch_abs[10:0]) * 15'(hbp_pkg::HBP_PITCH_SCALE);
	end

	// restoring divide, one quotient bit per cycle, MSB first
	assign dvs   = {5'b00000, lim_p} << cnt_q;
	assign trial = {1'b0, rem_q} - dvs;
	assign ge    = !trial[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbp_pkg::HBP_FS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd_valid = 1'b0;
		unique case (state_q)
			hbp_pkg::HBP_FS_IDLE: begin
				if (take) begin
					state_nxt = (lim_p == '0) ? hbp_pkg::HBP_FS_PUSH : hbp_pkg::HBP_FS_DIV;
				end
			end
			hbp_pkg::HBP_FS_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = hbp_pkg::HBP_FS_PUSH;
				end
			end
			hbp_pkg::HBP_FS_PUSH: begin
				cmd_valid = 1'b1;
				if (!cmd_stall) begin
					state_nxt = hbp_pkg::HBP_FS_IDLE;
				end
			end
			default: begin
				state_nxt = hbp_pkg::HBP_FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			roll_q <= roll_c[11:0];
			rem_q  <= prod25;
			quo_q  <= '0;
			neg_q  <= pitch_c[12];
			cnt_q  <= 3'(hbp_pkg::HBP_DIV_STEPS - 1);
		end else if (state_q == hbp_pkg::HBP_FS_DIV) begin
			if (ge) begin
				rem_q <= trial[14:0];
			end
			quo_q <= {quo_q[3:0], ge};
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_comb begin
		cmd.roll = roll_q;
		cmd.pofs = neg_q ? 7'(hbp_pkg::HBP_PITCH_BIAS) + {2'b00, quo_q}
		                 : 7'(hbp_pkg::HBP_PITCH_BIAS) - {2'b00, quo_q};
	end

endmodule

[sv/hbp_queue.sv]
// hbp_queue: small FIFO of hbp_cmd_t between front and back.
// Depends on hbp_pkg. DEPTH must be at least 2.
module hbp_queue #(
	parameter int DEPTH = hbp_pkg::HBP_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_stall,
	input  hbp_pkg::hbp_cmd_t wr_cmd,
	output logic              rd_valid,
	input  logic              rd_take,
	output hbp_pkg::hbp_cmd_t rd_cmd
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	hbp_pkg::hbp_cmd_t mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              push, pop;

	assign wr_stall = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_take && rd_valid;
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[sv/hbp_back.sv]
// hbp_back: column sequencer, one column offset per cycle while the output is not
// stalled, then row/level split and output register. Depends on hbp_pkg.
module hbp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hbp_pkg::hbp_cfg_t cfg,
	input  logic              cmd_valid,
	output logic              cmd_take,
	input  hbp_pkg::hbp_cmd_t cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output hbp_pkg::hbp_out_t out_req
);

	localparam logic [3:0] LAST_COL = 4'(hbp_pkg::HBP_COLS - 1);

	logic               active_q;
	logic [3:0]         col_q;
	logic signed [11:0] roll_q;
	logic [6:0]         pofs_q;

	logic               v_s1, last_s1;
	logic [6:0]         y_s1;
	logic signed [7:0]  scol_s1;

	logic              out_valid_q;
	hbp_pkg::hbp_out_t out_q;

	logic               en, adv, done, load;
	logic signed [3:0]  nx, nx_next;
	logic signed [8:0]  y_cur, y_next;
	logic               vis_cur, vis_next, last_cur;
	logic [7:0]         scol;

	logic [12:0] prod9;
	logic [3:0]  quo9;
	logic [6:0]  lvl;

	function automatic logic signed [8:0] col_y(input logic signed [11:0] roll,
		input logic signed [3:0] nxv, input logic [6:0] pofs);
		logic signed [15:0] t;
		logic signed [15:0] tb;
		logic signed [15:0] q;
		t  = roll * nxv;
		tb = t + (t[15] ? 16'((1 << hbp_pkg::HBP_ROLL_SHIFT) - 1) : 16'sd0);
		q  = tb >>> hbp_pkg::HBP_ROLL_SHIFT;
		return q[8:0] + $signed({2'b00, pofs});
	endfunction

	function automatic logic y_vis(input logic signed [8:0] y);
		return !y[8] && (y <= 9'sd0 + 9'(hbp_pkg::HBP_Y_MAX));
	endfunction

	assign en       = !out_valid_q || !out_stall;
	assign adv      = en && active_q;
	assign done     = adv && (col_q == LAST_COL);
	assign load     = cmd_valid && (!active_q || done);
	assign cmd_take = load;

	// nx = -x, x = col - span
	assign nx      = $signed(4'(hbp_pkg::HBP_COL_SPAN) - col_q);
	assign nx_next = nx - 4'sd1;
	assign y_cur   = col_y(roll_q, nx, pofs_q);
	assign y_next  = col_y(roll_q, nx_next, pofs_q);
	assign vis_cur  = y_vis(y_cur);
	assign vis_next = y_vis(y_next);
	// y is monotone in x, so visible columns are contiguous
	assign last_cur = vis_cur && ((col_q == LAST_COL) || !vis_next);
	assign scol     = {2'b00, cfg.center_col} + {4'b0000, col_q} - 8'(hbp_pkg::HBP_COL_SPAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= '0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				col_q    <= '0;
			end else begin
				if (done) begin
					active_q <= 1'b0;
				end
				if (adv) begin
					col_q <= col_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			roll_q <= cmd.roll;
			pofs_q <= cmd.pofs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= adv && vis_cur;
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1    <= y_cur[6:0];
			last_s1 <= last_cur;
			scol_s1 <= $signed(scol);
		end
	end

	// y / 9 by reciprocal multiply, exact for y <= 81
	assign prod9 = {6'b000000, y_s1} * 13'(hbp_pkg::HBP_DIV9_MUL);
	assign quo9  = 4'(prod9 >> hbp_pkg::HBP_DIV9_SHIFT);
	assign lvl   = y_s1 - 7'({3'b000, quo9} * 7'(hbp_pkg::HBP_BAR_LEVELS));

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.screen_col <= scol_s1;
			out_q.screen_row <= {1'b0, cfg.center_row} + {2'b00, quo9};
			out_q.bar_level  <= lvl[3:0];
			out_q.last_bar   <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_q;

endmodule

[sv/horizon_bar_placer_core.sv]
// horizon_bar_placer_core: top level of the horizon bar placer.
// The front clamps and scales each request in its 5-step divider (skipped with zero pitch
// limit); its holding register takes the next request while the divider is busy.
// The column sequencer walks the nine columns of a request, giving at most one result per
// cycle while the output is not stalled, and can load the next queued request on its last column.
// Reset: arst_n clears all control state; registers return to pitch 20, roll 40, rest 0.
// Depends on hbp_pkg, hbp_front, hbp_queue, hbp_back.
module horizon_bar_placer_core #(
	parameter int QUEUE_DEPTH = hbp_pkg::HBP_QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  hbp_pkg::hbp_in_t                    in_req,
	output logic                                out_valid,
	input  logic                                out_stall,
	output hbp_pkg::hbp_out_t                   out_req,
	input  logic                                cfg_we,
	input  logic [hbp_pkg::HBP_CFG_IDX_W-1:0]   cfg_index,
	input  logic [hbp_pkg::HBP_CFG_DATA_W-1:0]  cfg_data
);

	hbp_pkg::hbp_cfg_t cfg_q;
	hbp_pkg::hbp_cmd_t f_cmd, q_cmd;
	logic              f_valid, f_stall, q_valid, q_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pitch_deg <= hbp_pkg::HBP_RST_MAX_PITCH;
			cfg_q.max_roll_deg  <= hbp_pkg::HBP_RST_MAX_ROLL;
			cfg_q.invert_mode   <= 1'b0;
			cfg_q.center_col    <= '0;
			cfg_q.center_row    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbp_pkg::HBP_CFG_MAX_PITCH:  cfg_q.max_pitch_deg <= cfg_data[6:0];
				hbp_pkg::HBP_CFG_MAX_ROLL:   cfg_q.max_roll_deg  <= cfg_data[6:0];
				hbp_pkg::HBP_CFG_INVERT:     cfg_q.invert_mode   <= cfg_data[0];
				hbp_pkg::HBP_CFG_CENTER_COL: cfg_q.center_col    <= cfg_data[5:0];
				hbp_pkg::HBP_CFG_CENTER_ROW: cfg_q.center_row    <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	hbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.cfg       (cfg_q),
		.cmd_valid (f_valid),
		.cmd_stall (f_stall),
		.cmd       (f_cmd)
	);

	hbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_stall (f_stall),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_take  (q_take),
		.rd_cmd   (q_cmd)
	);

	hbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd_take  (q_take),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_req.bar_level < 4'(hbp_pkg::HBP_BAR_LEVELS)))
		else $error("bar level out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_req.screen_row >= {1'b0, cfg_q.center_row}) &&
			(out_req.screen_row <= {1'b0, cfg_q.center_row} + 6'd9))
		else $error("screen row outside bar span");

	a_queue_take: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !q_take)
		else $error("sequencer took from empty queue");

endmodule

[dv/hbp_bar_checker.sv]
`timescale 1ns / 1ps
// hbp_bar_checker: watches the request, result and register ports of
// horizon_bar_placer_core, predicts the bars of every attitude request and
// compares them in order. Depends on hbp_pkg.
module hbp_bar_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  hbp_pkg::hbp_in_t                    in_req,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  hbp_pkg::hbp_out_t                   out_req,
	input  logic                                cfg_we,
	input  logic [hbp_pkg::HBP_CFG_IDX_W-1:0]   cfg_index,
	input  logic [hbp_pkg::HBP_CFG_DATA_W-1:0]  cfg_data,
	output int                                  fail_count,
	output int                                  bars_pending
);
	import hbp_pkg::*;

	hbp_cfg_t shadow_cfg;
	hbp_out_t bars_q[$];
	int       errs = 0;

	function automatic hbp_cfg_t cfg_after_reset();
		hbp_cfg_t c;
		c = '0;
		c.max_pitch_deg = HBP_RST_MAX_PITCH;
		c.max_roll_deg = HBP_RST_MAX_ROLL;
		return c;
	endfunction

	// expected bars of one attitude, in column order
	function automatic void place_bars(hbp_in_t att);
		int roll, pitch, lim_r, lim_p, y;
		hbp_out_t held;
		bit have;
		roll = att.roll_angle;
		pitch = att.pitch_angle;
		lim_p = shadow_cfg.max_pitch_deg;
		lim_p = lim_p * 10;
		lim_r = shadow_cfg.max_roll_deg;
		lim_r = lim_r * 10;
		have = 1'b0;
		held = '0;
		if (shadow_cfg.invert_mode) begin
			roll = -roll;
			pitch = -pitch;
		end
		if (roll > lim_r) roll = lim_r;
		else if (roll < -lim_r) roll = -lim_r;
		if (pitch > lim_p) pitch = lim_p;
		else if (pitch < -lim_p) pitch = -lim_p;
		if (lim_p > 0)
			pitch = pitch * HBP_PITCH_SCALE / lim_p;
		pitch = pitch - HBP_PITCH_BIAS;
		for (int x = -HBP_COL_SPAN; x <= HBP_COL_SPAN; x++) begin
			y = (-roll * x) / 64 - pitch;
			if (y >= 0 && y <= HBP_Y_MAX) begin
				if (have)
					bars_q.insert(bars_q.size(), held);
				held.screen_col = 8'(int'(shadow_cfg.center_col) + x);
				held.screen_row = 6'(int'(shadow_cfg.center_row) + y / HBP_BAR_LEVELS);
				held.bar_level = 4'(y % HBP_BAR_LEVELS);
				held.last_bar = 1'b0;
				have = 1'b1;
			end
		end
		if (have) begin
			held.last_bar = 1'b1;
			bars_q.insert(bars_q.size(), held);
		end
	endfunction

	function automatic void field_check(string fname, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			errs++;
			$display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hbp_out_t want;
		if (!arst_n) begin
			shadow_cfg = cfg_after_reset();
			bars_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (bars_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected bar, expected none, got col=%0d row=%0d level=%0d last=%0b",
						$time, out_req.screen_col, out_req.screen_row, out_req.bar_level,
						out_req.last_bar);
				end else begin
					want = bars_q.pop_front();
					field_check("screen_col", want.screen_col, out_req.screen_col);
					field_check("screen_row", want.screen_row, out_req.screen_row);
					field_check("bar_level", want.bar_level, out_req.bar_level);
					field_check("last_bar", want.last_bar, out_req.last_bar);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					HBP_CFG_MAX_PITCH: shadow_cfg.max_pitch_deg = cfg_data;
					HBP_CFG_MAX_ROLL: shadow_cfg.max_roll_deg = cfg_data;
					HBP_CFG_INVERT: shadow_cfg.invert_mode = cfg_data[0];
					HBP_CFG_CENTER_COL: shadow_cfg.center_col = cfg_data[5:0];
					HBP_CFG_CENTER_ROW: shadow_cfg.center_row = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				place_bars(in_req);
		end
		fail_count <= errs;
		bars_pending <= bars_q.size();
	end

endmodule

[dv/tb_horizon_bar_placer_core.sv]
`timescale 1ns / 1ps
// tb_horizon_bar_placer_core: drives attitude requests and register settings
// into horizon_bar_placer_core and gives the verdict from hbp_bar_checker.
// Depends on hbp_pkg, horizon_bar_placer_core and hbp_bar_checker.
module tb_horizon_bar_placer_core;
	import hbp_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 120;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	hbp_in_t                    in_req = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	hbp_out_t                   out_req;
	logic                       cfg_we = 1'b0;
	logic [HBP_CFG_IDX_W-1:0]   cfg_index = '0;
	logic [HBP_CFG_DATA_W-1:0]  cfg_data = '0;
	int                         fail_count;
	int                         bars_pending;
	int                         cycles = 0;
	int                         stall_left = 0;
	bit                         steady = 1'b0;

	int dir_roll [9] = '{0, 1800, -1800, 2047, -2048, 400, -400, 123, -5};
	int dir_pitch [9] = '{0, -1800, 1800, 2047, -2048, 200, -201, 57, 7};

	horizon_bar_placer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_req(out_req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hbp_bar_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_req(out_req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.bars_pending(bars_pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("horizon_bar_placer_core: mismatch");
			$finish;
		end
	end

	// result side: after each accepted result, stall for a random hold, unless steady is set
	always @(posedge clk) begin
		int hold;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall && !steady) begin
			hold = $urandom_range(0, 10);
			out_stall <= (hold > 0);
			stall_left <= (hold > 0) ? hold - 1 : 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(logic [HBP_CFG_IDX_W-1:0] idx, logic [HBP_CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [6:0] p, logic [6:0] r, logic [6:0] inv,
			logic [6:0] col, logic [6:0] row);
		write_reg(HBP_CFG_MAX_PITCH, p);
		write_reg(HBP_CFG_MAX_ROLL, r);
		write_reg(HBP_CFG_INVERT, inv);
		write_reg(HBP_CFG_CENTER_COL, col);
		write_reg(HBP_CFG_CENTER_ROW, row);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_attitude(int roll, int pitch);
		int gap;
		hbp_in_t att;
		gap = steady ? 0 : $urandom_range(0, 10);
		att.roll_angle = roll[11:0];
		att.pitch_angle = pitch[11:0];
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req <= att;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_corners();
		send_attitude(2047, -2048);
		send_attitude(-2048, 2047);
		send_attitude(350, -120);
	endtask

	// drain all bars, then let any queued request finish
	task automatic settle();
		in_valid <= 1'b0;
		while (bars_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int random_angle();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 4095)) - 2048;
			1: return int'($urandom_range(0, 400)) - 200;
			default: return int'($urandom_range(0, 3600)) - 1800;
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 9; i++)
			send_attitude(dir_roll[i], dir_pitch[i]);
		settle();

		// zero limits, full-range settings, above-range limits, tiny limits
		apply_settings(7'd0, 7'd0, 7'd1, 7'd5, 7'd3);
		send_corners();
		settle();
		apply_settings(7'd90, 7'd90, 7'd1, 7'd63, 7'd31);
		send_corners();
		settle();
		apply_settings(7'd127, 7'd127, 7'd0, 7'd0, 7'd0);
		send_corners();
		settle();
		apply_settings(7'd1, 7'd1, 7'd0, 7'd63, 7'd0);
		send_corners();
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			steady = ($urandom_range(0, 3) == 0);
			apply_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)));
			for (int i = 0; i < 17; i++)
				send_attitude(random_angle(), random_angle());
			settle();
		end

		if (fail_count == 0 && bars_pending == 0)
			$display("horizon_bar_placer_core: match");
		else
			$display("horizon_bar_placer_core: mismatch");
		$finish;
	end

endmodule
